[design/led_strip_animator_defines.svh]
// Assertion macros shared by the LED strip animator RTL.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef LED_STRIP_ANIMATOR_DEFINES_SVH
`define LED_STRIP_ANIMATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/lsa_pkg.sv]
// Shared types and constants of the LED strip animator.
// No dependencies; used by lsa_cell, lsa_dimmer and led_strip_animator.
package lsa_pkg;

  localparam int COLOR_W   = 24;
  localparam int PAT_W     = 32;
  localparam int DIM_STEPS = 16;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ANIM_MODE    = 2'd0;
  localparam logic [1:0] REG_BASE_COLOR   = 2'd1;
  localparam logic [1:0] REG_PATTERN_BITS = 2'd2;
  localparam logic [1:0] REG_STRIP_LENGTH = 2'd3;

  // Animation modes
  localparam logic [2:0] ANIM_DARK     = 3'd0;
  localparam logic [2:0] ANIM_SOLID    = 3'd1;
  localparam logic [2:0] ANIM_RUN_FWD  = 3'd2;
  localparam logic [2:0] ANIM_RUN_REV  = 3'd3;
  localparam logic [2:0] ANIM_BOUNCE   = 3'd4;
  localparam logic [2:0] ANIM_STILL    = 3'd5;
  localparam logic [2:0] ANIM_SCROLL   = 3'd6;
  localparam logic [2:0] ANIM_PULSE    = 3'd7;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD      = 3'd0,
    CELL_FILL      = 3'd1,
    CELL_ONE_FIRST = 3'd2,
    CELL_ONE_LAST  = 3'd3,
    CELL_ROT_FWD   = 3'd4,
    CELL_ROT_REV   = 3'd5,
    CELL_PAINT     = 3'd6
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [COLOR_W-1:0]   color;
    logic [PAT_W-1:0]     bits;
  } cell_cmd_t;

  // Dimming curve, brightest first
  function automatic logic [7:0] dim_level(input logic [3:0] step);
    logic [7:0] lvl;
    case (step)
      4'd0:    lvl = 8'd235;
      4'd1:    lvl = 8'd206;
      4'd2:    lvl = 8'd179;
      4'd3:    lvl = 8'd154;
      4'd4:    lvl = 8'd131;
      4'd5:    lvl = 8'd110;
      4'd6:    lvl = 8'd91;
      4'd7:    lvl = 8'd74;
      4'd8:    lvl = 8'd59;
      4'd9:    lvl = 8'd46;
      4'd10:   lvl = 8'd35;
      4'd11:   lvl = 8'd26;
      4'd12:   lvl = 8'd19;
      4'd13:   lvl = 8'd14;
      4'd14:   lvl = 8'd11;
      default: lvl = 8'd10;
    endcase
    return lvl;
  endfunction

endpackage

[design/lsa_cell.sv]
// One LED cell of the animator chain: holds a 24-bit color.
// Depends on lsa_pkg for the broadcast command.
module lsa_cell import lsa_pkg::*; #(
  parameter int MAX_LEDS = 32,
  parameter int IDX      = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cell_cmd_t                           cmd,
  input  logic [$clog2(MAX_LEDS+1)-1:0]       n,
  input  logic [COLOR_W-1:0]                  prev_color,
  input  logic [COLOR_W-1:0]                  next_color,
  input  logic [COLOR_W-1:0]                  head_color,
  output logic [COLOR_W-1:0]                  color
);

  localparam int N_W = $clog2(MAX_LEDS + 1);

  logic                in_use;
  logic                is_last;
  logic [COLOR_W-1:0]  color_next;

  assign in_use  = N_W'(IDX) < n;
  assign is_last = N_W'(IDX + 1) == n;

  always_comb begin
    color_next = color;
    if (in_use) begin
      unique case (cmd.op)
        CELL_FILL:      color_next = cmd.color;
        CELL_ONE_FIRST: color_next = (IDX == 0) ? cmd.color : '0;
        CELL_ONE_LAST:  color_next = is_last ? cmd.color : '0;
        CELL_ROT_FWD:   color_next = prev_color;
        // wrap the head around to the last cell in use
        CELL_ROT_REV:   color_next = is_last ? head_color : next_color;
        CELL_PAINT:     color_next = cmd.bits[IDX] ? cmd.color : '0;
        default:        color_next = color;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= '0;
    end else begin
      color <= color_next;
    end
  end

endmodule

[design/lsa_dimmer.sv]
// Breathe-mode dimmer: scales each channel of a color by the dimming curve.
// Depends on lsa_pkg for dim_level.
module lsa_dimmer import lsa_pkg::*; (
  input  logic [COLOR_W-1:0] color_in,
  input  logic [3:0]         step,
  output logic [COLOR_W-1:0] color_out
);

  logic [7:0] level;

  assign level = dim_level(step);

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [7:0]  chan;
    logic [15:0] prod;
    assign chan = color_in[c*8 +: 8];
    assign prod = 16'(chan) * 16'(level);
    // black stays black, anything else gets the rounding step
    assign color_out[c*8 +: 8] = (chan == 8'd0) ? 8'd0 : prod[15:8] + 8'd1;
  end

endmodule

[design/led_strip_animator.sv]
// LED strip animator top level: config registers, tick control and frame output.
// Depends on lsa_pkg, lsa_cell, lsa_dimmer and led_strip_animator_defines.svh.
//
// Usage:
//   s_* carries tick beats. Each accepted tick advances the animation one step
//   in the accept cycle itself, then the frame leaves on m_* as one beat per
//   LED in use, LED 0 first, m_tlast on the last LED.
//   After a tick is taken the sequencer enters ST_EMIT and loads the first LED
//   beat into the output register once it is free. The cell chain rotates one
//   position per emitted beat and is back in place after the last one.
//   s_tready is high only between frames; a tick may be taken while the last
//   beat of the previous frame still sits in the output register.
//   If m_tready is low, the output register holds its beat and the chain
//   stops rotating until the beat is taken.
//   The configuration port writes one register per cycle with cfg_we high;
//   every write makes the next tick run the mode's start step. Write only
//   between frames.
//   Reset (rst, synchronous) clears all LEDs to black, loads the register
//   defaults (mode off, strip length 32) and arms the start step.
`include "led_strip_animator_defines.svh"

module led_strip_animator import lsa_pkg::*; #(
  parameter int MAX_LEDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // tick channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart
  // frame channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] led_index, [12:5] red, [20:13] green, [28:21] blue
  output logic        m_tlast,   // frame_end
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int N_W   = $clog2(MAX_LEDS + 1);
  localparam int CNT_W = $clog2(MAX_LEDS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;

  // configuration registers
  logic [2:0]         anim_mode;
  logic [COLOR_W-1:0] base_color;
  logic [PAT_W-1:0]   pattern_bits;
  logic [5:0]         strip_length;

  // animation state
  logic               starting;
  logic               moving_back;
  logic               moving_back_next;
  logic [3:0]         dim_step;
  logic [3:0]         dim_step_next;
  logic [PAT_W-1:0]   rot_pattern;
  logic [PAT_W-1:0]   rot_pattern_next;

  // frame output
  logic [CNT_W-1:0]   emit_cnt;
  logic [CNT_W-1:0]   out_index;
  logic [COLOR_W-1:0] out_color;

  logic [N_W-1:0]     n;
  logic [5:0]         n6;
  logic [CNT_W-1:0]   last_pos;
  logic               accept;
  logic               emit_load;
  logic               st;
  logic [COLOR_W-1:0] colors [MAX_LEDS];
  logic [COLOR_W-1:0] tail_color;
  logic [COLOR_W-1:0] dim_color;
  logic [3:0]         dim_eff;
  logic               back_eff;
  logic [PAT_W-1:0]   used_mask;
  logic [PAT_W-1:0]   pat_masked;
  logic               wrap_bit;
  cell_cmd_t          cmd;

  // ---- configuration -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      anim_mode    <= ANIM_DARK;
      base_color   <= '0;
      pattern_bits <= '0;
      strip_length <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANIM_MODE:    anim_mode    <= cfg_data[2:0];
        REG_BASE_COLOR:   base_color   <= cfg_data[COLOR_W-1:0];
        REG_PATTERN_BITS: pattern_bits <= cfg_data[PAT_W-1:0];
        REG_STRIP_LENGTH: strip_length <= cfg_data[5:0];
        default:          anim_mode    <= anim_mode;
      endcase
    end
  end

  // Clamp the strip length: zero counts as one LED, long strips stop at the chain
  always_comb begin
    if (strip_length == 6'd0) begin
      n = N_W'(1);
    end else if (strip_length > 6'(MAX_LEDS)) begin
      n = N_W'(MAX_LEDS);
    end else begin
      n = N_W'(strip_length);
    end
  end

  assign n6       = 6'(n);
  assign last_pos = CNT_W'(n - N_W'(1));

  // ---- handshake -----------------------------------------------------------
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign emit_load = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign st        = starting || s_tdata[0];

  // ---- cell chain ----------------------------------------------------------
  assign tail_color = colors[last_pos];

  for (genvar g = 0; g < MAX_LEDS; g++) begin : g_cell
    logic [COLOR_W-1:0] prev_c;
    logic [COLOR_W-1:0] next_c;
    if (g == 0) begin : g_first
      assign prev_c = tail_color;
    end else begin : g_mid_prev
      assign prev_c = colors[g-1];
    end
    if (g == MAX_LEDS - 1) begin : g_end
      assign next_c = colors[0];
    end else begin : g_mid_next
      assign next_c = colors[g+1];
    end
    lsa_cell #(
      .MAX_LEDS (MAX_LEDS),
      .IDX      (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .n          (n),
      .prev_color (prev_c),
      .next_color (next_c),
      .head_color (colors[0]),
      .color      (colors[g])
    );
  end

  // ---- breathe -------------------------------------------------------------
  assign dim_eff  = st ? 4'd0 : dim_step;
  assign back_eff = st ? 1'b0 : moving_back;

  lsa_dimmer u_dimmer (
    .color_in  (base_color),
    .step      (dim_eff),
    .color_out (dim_color)
  );

  // ---- marquee: rotate left within the LEDs in use -------------------------
  always_comb begin
    for (int j = 0; j < PAT_W; j++) begin
      used_mask[j] = 6'(j) < n6;
    end
  end

  assign pat_masked = rot_pattern & used_mask;
  assign wrap_bit   = pat_masked[5'(n6 - 6'd1)];

  // ---- tick step and chain command -----------------------------------------
  always_comb begin
    cmd              = '{op: CELL_HOLD, color: '0, bits: '0};
    moving_back_next = moving_back;
    dim_step_next    = dim_step;
    rot_pattern_next = rot_pattern;
    if (accept) begin
      unique case (anim_mode)
        ANIM_DARK: begin
          if (st) cmd.op = CELL_FILL;
        end
        ANIM_SOLID: begin
          cmd.color = base_color;
          if (st) cmd.op = CELL_FILL;
        end
        ANIM_RUN_FWD: begin
          cmd.color = base_color;
          cmd.op    = st ? CELL_ONE_FIRST : CELL_ROT_FWD;
        end
        ANIM_RUN_REV: begin
          cmd.color = base_color;
          cmd.op    = st ? CELL_ONE_LAST : CELL_ROT_REV;
        end
        ANIM_BOUNCE: begin
          cmd.color = base_color;
          if (st) begin
            cmd.op           = CELL_ONE_FIRST;
            moving_back_next = 1'b0;
          end else if (!moving_back) begin
            // pause one tick at the far end, then turn
            if (tail_color == base_color) moving_back_next = 1'b1;
            else cmd.op = CELL_ROT_FWD;
          end else begin
            if (colors[0] == base_color) moving_back_next = 1'b0;
            else cmd.op = CELL_ROT_REV;
          end
        end
        ANIM_STILL: begin
          cmd.color = base_color;
          cmd.bits  = pattern_bits;
          if (st) cmd.op = CELL_PAINT;
        end
        ANIM_SCROLL: begin
          rot_pattern_next = st ? (pattern_bits & used_mask)
                                : ({pat_masked[PAT_W-2:0], wrap_bit} & used_mask);
          cmd.op    = CELL_PAINT;
          cmd.color = base_color;
          cmd.bits  = rot_pattern_next;
        end
        ANIM_PULSE: begin
          cmd.op           = CELL_FILL;
          cmd.color        = dim_color;
          moving_back_next = back_eff;
          dim_step_next    = dim_eff;
          // hold each end level for one extra tick before turning
          if (!back_eff) begin
            if (dim_eff >= 4'(DIM_STEPS - 1)) moving_back_next = 1'b1;
            else dim_step_next = dim_eff + 4'd1;
          end else begin
            if (dim_eff == 4'd0) moving_back_next = 1'b0;
            else dim_step_next = dim_eff - 4'd1;
          end
        end
        default: cmd.op = CELL_HOLD;
      endcase
    end else if (emit_load) begin
      // shift the next LED into cell 0; n shifts restore the frame
      cmd.op = CELL_ROT_REV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      starting    <= 1'b1;
      moving_back <= 1'b0;
      dim_step    <= 4'd0;
      rot_pattern <= '0;
    end else begin
      if (cfg_we) starting <= 1'b1;
      else if (accept) starting <= 1'b0;
      moving_back <= moving_back_next;
      dim_step    <= dim_step_next;
      rot_pattern <= rot_pattern_next;
    end
  end

  // ---- frame sequencer -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      emit_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state    <= ST_EMIT;
            emit_cnt <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            emit_cnt <= emit_cnt + CNT_W'(1);
            if (emit_cnt == last_pos) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (emit_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // output beat register, loaded from the head of the chain
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_index <= emit_cnt;
      out_color <= colors[0];
      m_tlast   <= (emit_cnt == last_pos);
    end
  end

  assign m_tdata = {3'b000, out_color[7:0], out_color[15:8], out_color[23:16],
                    5'(out_index)};

  // ---- checks --------------------------------------------------------------
  `LSA_ASSERT_NEXT(a_tick_starts_frame, s_tvalid && s_tready, (state == ST_EMIT) && (emit_cnt == '0), "tick did not start a frame at LED 0")
  `LSA_ASSERT_IMPL(a_emit_in_strip, state == ST_EMIT, N_W'(emit_cnt) < n, "LED counter ran past the strip")
  `LSA_ASSERT_IMPL(a_last_on_end_led, m_tvalid && m_tlast, out_index == last_pos, "frame end not on the last LED")

endmodule
